[rtl/core/irpe_pkg.sv]
// shared types, codes and constants of the ir remote pulse encoder
package irpe_pkg;

  // field and register widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned PROTO_W  = 2;
  localparam int unsigned UNIT_W   = 11;
  localparam int unsigned DUR_W    = 15;
  localparam int unsigned SEG_W    = 5;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // bit field length limit, never above the data width
  localparam int unsigned MAX_BITS  = 16;
  localparam int unsigned BIT_LIMIT = (MAX_BITS < DATA_W) ? MAX_BITS : DATA_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_LEADER    = 2'd0;
  localparam logic [OP_W-1:0] OP_FIELD     = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP      = 2'd2;
  localparam logic [OP_W-1:0] OP_BYTE_PAIR = 2'd3;

  // protocol codes
  localparam logic [PROTO_W-1:0] PROTO_DIST_A = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_DIST_B = 2'd1;
  localparam logic [PROTO_W-1:0] PROTO_WIDTH  = 2'd2;
  localparam logic [PROTO_W-1:0] PROTO_ALIAS  = 2'd3;

  // register indexes and reset values
  localparam logic REG_PROTOCOL  = 1'b0;
  localparam logic REG_UNIT_TIME = 1'b1;
  localparam logic [PROTO_W-1:0] PROTO_RESET = PROTO_DIST_A;
  localparam logic [UNIT_W-1:0]  UNIT_RESET  = 11'd562;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } irpe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic last_seg;
  } irpe_status_t;

endpackage

[rtl/core/irpe_ctrl.sv]
// controller state machine of the ir remote pulse encoder
module irpe_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  irpe_pkg::irpe_status_t status,
  output irpe_pkg::irpe_cmd_t   cmd,
  output logic                  busy,
  output logic                  seg_valid
);
  import irpe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!status.empty) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_seg) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign seg_valid = (state_r == ST_RUN);

endmodule

[rtl/core/irpe_dp.sv]
// segment datapath: request latch, segment counter, bit shifter, duration select
module irpe_dp (
  input  logic                          clk,
  input  irpe_pkg::irpe_cmd_t           cmd,
  input  logic [irpe_pkg::OP_W-1:0]     in_operation,
  input  logic                          in_repeat_frame,
  input  logic [irpe_pkg::DATA_W-1:0]   in_data_value,
  input  logic [irpe_pkg::CNT_W-1:0]    in_bit_count,
  input  logic [irpe_pkg::PROTO_W-1:0]  protocol,
  input  logic [irpe_pkg::UNIT_W-1:0]   unit_time,
  output irpe_pkg::irpe_status_t        status,
  output logic                          seg_level,
  output logic [irpe_pkg::DUR_W-1:0]    seg_duration,
  output logic                          seg_last
);
  import irpe_pkg::*;

  logic [OP_W-1:0]    op_r;
  logic               rep_r;
  logic [DATA_W-1:0]  shift_r, shift_nxt;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic [SEG_W-1:0]   last_idx_r, last_idx_nxt;

  logic [PROTO_W-1:0] proto_eff;
  logic               width_rule;
  logic [CNT_W-1:0]   cnt_sat;
  logic               empty_req;

  // protocol three behaves as protocol zero
  assign proto_eff  = (protocol == PROTO_ALIAS) ? PROTO_DIST_A : protocol;
  assign width_rule = (proto_eff == PROTO_WIDTH);

  // saturated bit count of a bit field request
  assign cnt_sat = (in_bit_count > CNT_W'(BIT_LIMIT)) ? CNT_W'(BIT_LIMIT) : in_bit_count;

  // segment count of the incoming request, as last index and empty flag
  always_comb begin
    empty_req    = 1'b0;
    last_idx_nxt = '0;
    case (in_operation)
      OP_LEADER: begin
        last_idx_nxt = width_rule ? SEG_W'(0) : SEG_W'(1);
      end
      OP_FIELD: begin
        empty_req    = (cnt_sat == '0);
        last_idx_nxt = SEG_W'({cnt_sat, 1'b0} - 6'd1);
      end
      OP_STOP: begin
        empty_req    = width_rule;
        last_idx_nxt = SEG_W'(1);
      end
      OP_BYTE_PAIR: begin
        last_idx_nxt = SEG_W'(31);
      end
      default: begin
        last_idx_nxt = '0;
      end
    endcase
  end

  assign status.empty    = empty_req;
  assign status.last_seg = (seg_r == last_idx_r);

  // shifter and segment counter
  always_comb begin
    shift_nxt = shift_r;
    seg_nxt   = seg_r;
    if (cmd.load) begin
      shift_nxt = (in_operation == OP_BYTE_PAIR) ?
                  {~in_data_value[7:0], in_data_value[7:0]} : in_data_value;
      seg_nxt   = '0;
    end else if (cmd.step) begin
      seg_nxt = seg_r + SEG_W'(1);
      if (seg_r[0]) begin
        shift_nxt = shift_r >> 1;
      end
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    seg_r   <= seg_nxt;
    if (cmd.load) begin
      op_r       <= in_operation;
      rep_r      <= in_repeat_frame;
      last_idx_r <= last_idx_nxt;
    end
  end

  // multiples of the unit time
  logic [DUR_W-1:0] t1, t2, t3, t4, t8, t16;
  assign t1  = DUR_W'(unit_time);
  assign t2  = DUR_W'({unit_time, 1'b0});
  assign t3  = t1 + t2;
  assign t4  = DUR_W'({unit_time, 2'b00});
  assign t8  = DUR_W'({unit_time, 3'b000});
  assign t16 = DUR_W'({unit_time, 4'b0000});

  // level and duration of the current segment
  always_comb begin
    seg_level    = 1'b0;
    seg_duration = t1;
    case (op_r)
      OP_LEADER: begin
        seg_level = ~seg_r[0];
        case (proto_eff)
          PROTO_DIST_B: seg_duration = seg_r[0] ? (rep_r ? t8 : t4) : t8;
          PROTO_WIDTH:  seg_duration = t4;
          default:      seg_duration = seg_r[0] ? (rep_r ? t4 : t8) : t16;
        endcase
      end
      OP_STOP: begin
        seg_level    = ~seg_r[0];
        seg_duration = t1;
      end
      default: begin
        // data bit: first half then second half
        if (width_rule) begin
          seg_level    = seg_r[0];
          seg_duration = (seg_r[0] && shift_r[0]) ? t2 : t1;
        end else begin
          seg_level    = ~seg_r[0];
          seg_duration = (seg_r[0] && shift_r[0]) ? t3 : t1;
        end
      end
    endcase
  end

  assign seg_last = status.last_seg;

endmodule

[rtl/core/ir_remote_pulse_encoder_unit.sv]
// top level of the ir remote pulse encoder: registers, controller and datapath
//
// A request names one piece of an infrared remote frame: leader, bit field,
// stop bit or a byte followed by its complement. It is taken at a rising edge
// with start high and busy low. The block then emits the mark and space
// segments of that piece, one per cycle, each as out_level and out_duration
// (microseconds) with out_valid high for exactly one cycle; out_last marks
// the final segment of the request.
// A request keeps busy high from acceptance until its final segment is out;
// the segment counter of the datapath sets this. The longest request is a
// byte and its complement, with 32 segments. A request that makes no
// segment (empty bit field, stop bit under the pulse width rule) is taken
// and leaves busy low.
// The receiver cannot stall; segments are produced at one per cycle.
// The protocol and unit time registers sit on the apb port at byte addresses
// 0 and 4; the user must write them only while idle, as nothing checks this.
// Reset (rst_n low, synchronous) returns the controller to idle and the
// registers to protocol 0 and unit time 562.
module ir_remote_pulse_encoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [irpe_pkg::OP_W-1:0]     in_operation,
  input  logic                          in_repeat_frame,
  input  logic [irpe_pkg::DATA_W-1:0]   in_data_value,
  input  logic [irpe_pkg::CNT_W-1:0]    in_bit_count,
  // segment channel
  output logic                          out_valid,
  output logic                          out_level,
  output logic [irpe_pkg::DUR_W-1:0]    out_duration,
  output logic                          out_last,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpe_pkg::APB_AW-1:0]   paddr,
  input  logic [irpe_pkg::APB_DW-1:0]   pwdata,
  output logic [irpe_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import irpe_pkg::*;

  logic [PROTO_W-1:0] protocol_r;
  logic [UNIT_W-1:0]  unit_time_r;
  logic               reg_wr;
  logic               reg_idx;

  irpe_cmd_t    cmd;
  irpe_status_t status;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_r  <= PROTO_RESET;
      unit_time_r <= UNIT_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_PROTOCOL:  protocol_r  <= pwdata[PROTO_W-1:0];
        REG_UNIT_TIME: unit_time_r <= pwdata[UNIT_W-1:0];
        default:       protocol_r  <= protocol_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_PROTOCOL:  prdata = APB_DW'(protocol_r);
      REG_UNIT_TIME: prdata = APB_DW'(unit_time_r);
      default:       prdata = '0;
    endcase
  end

  irpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .seg_valid (out_valid)
  );

  irpe_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_repeat_frame (in_repeat_frame),
    .in_data_value   (in_data_value),
    .in_bit_count    (in_bit_count),
    .protocol        (protocol_r),
    .unit_time       (unit_time_r),
    .status          (status),
    .seg_level       (out_level),
    .seg_duration    (out_duration),
    .seg_last        (out_last)
  );

endmodule
